FILE: rtl/smoothed_servo_pulse_mixer_defines.svh
// ----------------------------------------------------------------------------
// Smoothed servo pulse mixer: assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef SMOOTHED_SERVO_PULSE_MIXER_DEFINES_SVH
`define SMOOTHED_SERVO_PULSE_MIXER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSPM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sspm assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SSPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sspm assertion failed");

`endif

FILE: rtl/sspm_pkg.sv
// ----------------------------------------------------------------------------
// sspm_pkg
// Widths, register indexes, reset values and arithmetic constants of the
// smoothed servo pulse mixer.
// ----------------------------------------------------------------------------
package sspm_pkg;

  localparam int CMD_W      = 14;
  localparam int THR_CMD_W  = 17;
  localparam int ANG_W      = 16;
  localparam int THR_W      = 19;
  localparam int SERVO_US_W = 12;
  localparam int ESC_US_W   = 11;
  localparam int OFFSET_W   = 8;
  localparam int MASK_W     = 4;
  localparam int TRAVEL_W   = 7;
  localparam int CAP_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_LA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_RA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_LT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_RT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_MASK  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_CAP   = 3'd6;

  localparam logic [OFFSET_W-1:0] RST_OFFSET_LA = 8'd90;
  localparam logic [OFFSET_W-1:0] RST_OFFSET_RA = 8'd87;
  localparam logic [OFFSET_W-1:0] RST_OFFSET_LT = 8'd100;
  localparam logic [OFFSET_W-1:0] RST_OFFSET_RT = 8'd90;
  localparam logic [MASK_W-1:0]   RST_REV_MASK  = 4'd5;
  localparam logic [TRAVEL_W-1:0] RST_TRAVEL    = 7'd30;
  localparam logic [CAP_W-1:0]    RST_THR_CAP   = 7'd60;

  localparam logic [ANG_W-1:0] ANGLE_RESET = 16'd23040;

  // Surface path, angles in 1/256 degree.
  localparam logic signed [17:0] HALF_TURN   = 18'sd46080;
  localparam logic signed [17:0] DEG_HALF    = 18'sd128;
  localparam logic signed [10:0] NEUTRAL_DEG = 11'sd90;
  localparam logic signed [10:0] MAX_DEG     = 11'sd180;
  localparam logic [SERVO_US_W-1:0] SERVO_BASE_US = 12'd500;
  // floor(deg*100/9) == (deg * 100 * 14564) >> 17 for deg in 0..180.
  localparam logic [20:0] PULSE_MULT  = 21'd1456400;
  localparam int          PULSE_SHIFT = 17;

  // Throttle path, Q18.
  localparam logic [THR_W-1:0]    THR_ONE     = 19'd262144;
  localparam logic [28:0]         THR_HALF    = 29'd131072;
  localparam int                  THR_SHIFT   = 18;
  localparam logic [CAP_W-1:0]    CAP_MAX     = 7'd100;
  localparam logic [ESC_US_W-1:0] ESC_BASE_US = 11'd1000;

endpackage

FILE: rtl/sspm_in_if.sv
// ----------------------------------------------------------------------------
// sspm_in_if
// Command channel: four surface angle commands and a throttle command.
// ----------------------------------------------------------------------------
interface sspm_in_if;
  import sspm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     left_aileron_cmd;
  logic [CMD_W-1:0]     right_aileron_cmd;
  logic [CMD_W-1:0]     left_tail_cmd;
  logic [CMD_W-1:0]     right_tail_cmd;
  logic [THR_CMD_W-1:0] throttle_cmd;

  modport source (
    output valid, left_aileron_cmd, right_aileron_cmd, left_tail_cmd,
           right_tail_cmd, throttle_cmd,
    input  ready
  );
  modport sink (
    input  valid, left_aileron_cmd, right_aileron_cmd, left_tail_cmd,
           right_tail_cmd, throttle_cmd,
    output ready
  );
endinterface

FILE: rtl/sspm_out_if.sv
// ----------------------------------------------------------------------------
// sspm_out_if
// Pulse channel: four servo pulse widths and a motor controller pulse width.
// ----------------------------------------------------------------------------
interface sspm_out_if;
  import sspm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [SERVO_US_W-1:0] left_aileron_pulse_us;
  logic [SERVO_US_W-1:0] right_aileron_pulse_us;
  logic [SERVO_US_W-1:0] left_tail_pulse_us;
  logic [SERVO_US_W-1:0] right_tail_pulse_us;
  logic [ESC_US_W-1:0]   throttle_pulse_us;

  modport source (
    output valid, left_aileron_pulse_us, right_aileron_pulse_us,
           left_tail_pulse_us, right_tail_pulse_us, throttle_pulse_us,
    input  ready
  );
  modport sink (
    input  valid, left_aileron_pulse_us, right_aileron_pulse_us,
           left_tail_pulse_us, right_tail_pulse_us, throttle_pulse_us,
    output ready
  );
endinterface

FILE: rtl/smoothed_servo_pulse_mixer.sv
// A word accepted enters the first stage, the smoother state registers, then moves
// into the output register. Throughput: one word per cycle unless the output stalls.
// A word enters whenever the first stage is empty or moves into the output register.
// Reset (synchronous, rst_n low) clears both valid flags, loads the registers with
// their default settings and sets the angle smoothers to 90 degrees, throttle to 0.
// ----------------------------------------------------------------------------
// smoothed_servo_pulse_mixer
// First-order smoothing of four surface commands and a throttle command,
// mixed into servo and motor controller pulse widths.
// ----------------------------------------------------------------------------
`include "smoothed_servo_pulse_mixer_defines.svh"

module smoothed_servo_pulse_mixer (
  input  logic                            clk,
  input  logic                            rst_n,
  sspm_in_if.sink                         in_ch,
  sspm_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [sspm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sspm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sspm_pkg::*;

  logic [OFFSET_W-1:0] off_la_r, off_ra_r, off_lt_r, off_rt_r;
  logic [MASK_W-1:0]   rev_mask_r;
  logic [TRAVEL_W-1:0] travel_r;
  logic [CAP_W-1:0]    thr_cap_r;

  logic [ANG_W-1:0] la_smooth_r, ra_smooth_r, lt_smooth_r, rt_smooth_r;
  logic [ANG_W-1:0] la_smooth_nxt, ra_smooth_nxt, lt_smooth_nxt, rt_smooth_nxt;
  logic [THR_W-1:0] thr_smooth_r, thr_smooth_nxt;

  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic advance;
  logic accept;

  logic [SERVO_US_W-1:0] la_pulse, ra_pulse, lt_pulse, rt_pulse;
  logic [SERVO_US_W-1:0] la_pulse_r, ra_pulse_r, lt_pulse_r, rt_pulse_r;
  logic [ESC_US_W-1:0]   thr_pulse, thr_pulse_r;

  logic [THR_W-1:0]    thr_lim;
  logic [CAP_W-1:0]    cap_lim;
  logic [9:0]          cap_x10;
  logic [28:0]         thr_prod;
  logic [ESC_US_W-1:0] thr_us;
  logic [ESC_US_W-1:0] thr_top;

  // One smoother step: prev + floor((target - prev) / 4).
  function automatic logic [ANG_W-1:0] smooth_ang(input logic [ANG_W-1:0] prev,
                                                  input logic [CMD_W-1:0] cmd);
    logic signed [ANG_W:0] diff;
    logic signed [ANG_W:0] sum;
    diff = $signed({1'b0, cmd, 2'b00}) - $signed({1'b0, prev});
    sum  = $signed({1'b0, prev}) + (diff >>> 2);
    return sum[ANG_W-1:0];
  endfunction

  always_comb begin
    advance       = !out_valid_r || out_ch.ready;
    in_ch.ready   = !s1_valid_r || advance;
    accept        = in_ch.valid && in_ch.ready;
    s1_valid_nxt  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = advance ? s1_valid_r : out_valid_r;
  end

  always_comb begin
    logic signed [THR_W:0] thr_diff;
    logic signed [THR_W:0] thr_sum;
    la_smooth_nxt  = smooth_ang(la_smooth_r, in_ch.left_aileron_cmd);
    ra_smooth_nxt  = smooth_ang(ra_smooth_r, in_ch.right_aileron_cmd);
    lt_smooth_nxt  = smooth_ang(lt_smooth_r, in_ch.left_tail_cmd);
    rt_smooth_nxt  = smooth_ang(rt_smooth_r, in_ch.right_tail_cmd);
    thr_diff       = $signed({1'b0, in_ch.throttle_cmd, 2'b00})
                     - $signed({1'b0, thr_smooth_r});
    thr_sum        = $signed({1'b0, thr_smooth_r}) + (thr_diff >>> 2);
    thr_smooth_nxt = thr_sum[THR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_la_r   <= RST_OFFSET_LA;
      off_ra_r   <= RST_OFFSET_RA;
      off_lt_r   <= RST_OFFSET_LT;
      off_rt_r   <= RST_OFFSET_RT;
      rev_mask_r <= RST_REV_MASK;
      travel_r   <= RST_TRAVEL;
      thr_cap_r  <= RST_THR_CAP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFSET_LA: off_la_r   <= cfg_wdata;
        CFG_OFFSET_RA: off_ra_r   <= cfg_wdata;
        CFG_OFFSET_LT: off_lt_r   <= cfg_wdata;
        CFG_OFFSET_RT: off_rt_r   <= cfg_wdata;
        CFG_REV_MASK:  rev_mask_r <= cfg_wdata[MASK_W-1:0];
        CFG_TRAVEL:    travel_r   <= cfg_wdata[TRAVEL_W-1:0];
        CFG_THR_CAP:   thr_cap_r  <= cfg_wdata[CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      la_smooth_r  <= ANGLE_RESET;
      ra_smooth_r  <= ANGLE_RESET;
      lt_smooth_r  <= ANGLE_RESET;
      rt_smooth_r  <= ANGLE_RESET;
      thr_smooth_r <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        la_smooth_r  <= la_smooth_nxt;
        ra_smooth_r  <= ra_smooth_nxt;
        lt_smooth_r  <= lt_smooth_nxt;
        rt_smooth_r  <= rt_smooth_nxt;
        thr_smooth_r <= thr_smooth_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  sspm_surface u_surf_la (
    .angle(la_smooth_r), .reversed(rev_mask_r[0]), .offset(off_la_r),
    .travel(travel_r), .pulse_us(la_pulse)
  );
  sspm_surface u_surf_ra (
    .angle(ra_smooth_r), .reversed(rev_mask_r[1]), .offset(off_ra_r),
    .travel(travel_r), .pulse_us(ra_pulse)
  );
  sspm_surface u_surf_lt (
    .angle(lt_smooth_r), .reversed(rev_mask_r[2]), .offset(off_lt_r),
    .travel(travel_r), .pulse_us(lt_pulse)
  );
  sspm_surface u_surf_rt (
    .angle(rt_smooth_r), .reversed(rev_mask_r[3]), .offset(off_rt_r),
    .travel(travel_r), .pulse_us(rt_pulse)
  );

  // Throttle: limit to full scale, scale by the cap and round half up.
  always_comb begin
    thr_lim   = (thr_smooth_r > THR_ONE) ? THR_ONE : thr_smooth_r;
    cap_lim   = (thr_cap_r > CAP_MAX) ? CAP_MAX : thr_cap_r;
    cap_x10   = {cap_lim, 3'b000} + {2'b00, cap_lim, 1'b0};
    thr_prod  = 29'(thr_lim) * 29'(cap_x10);
    thr_us    = ESC_BASE_US + ESC_US_W'((thr_prod + THR_HALF) >> THR_SHIFT);
    thr_top   = ESC_BASE_US + ESC_US_W'(cap_x10);
    thr_pulse = (thr_us > thr_top) ? thr_top : thr_us;
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      la_pulse_r  <= la_pulse;
      ra_pulse_r  <= ra_pulse;
      lt_pulse_r  <= lt_pulse;
      rt_pulse_r  <= rt_pulse;
      thr_pulse_r <= thr_pulse;
    end
  end

  assign out_ch.valid                  = out_valid_r;
  assign out_ch.left_aileron_pulse_us  = la_pulse_r;
  assign out_ch.right_aileron_pulse_us = ra_pulse_r;
  assign out_ch.left_tail_pulse_us     = lt_pulse_r;
  assign out_ch.right_tail_pulse_us    = rt_pulse_r;
  assign out_ch.throttle_pulse_us      = thr_pulse_r;

  // A full first stage moves into the output register whenever that frees up.
  `SSPM_ASSERT_NEXT(a_stage_moves, s1_valid_r && advance, out_valid_r)
  // A stalled first stage keeps its word and its smoother state.
  `SSPM_ASSERT_NEXT(a_stage_holds, s1_valid_r && !advance,
                    s1_valid_r && $stable(la_smooth_r) && $stable(thr_smooth_r))
  `SSPM_ASSERT_SAME(a_thr_range, out_valid_r,
                    thr_pulse_r >= ESC_BASE_US && thr_pulse_r <= 11'd2000)
  `SSPM_ASSERT_SAME(a_servo_range, out_valid_r,
                    la_pulse_r >= SERVO_BASE_US && la_pulse_r <= 12'd2500)

endmodule

FILE: rtl/sspm_surface.sv
// ----------------------------------------------------------------------------
// sspm_surface
// Smoothed angle to servo pulse: reverse, round to degrees, offset, clamp
// and scale to microseconds.
// ----------------------------------------------------------------------------
module sspm_surface (
  input  logic [sspm_pkg::ANG_W-1:0]      angle,
  input  logic                            reversed,
  input  logic [sspm_pkg::OFFSET_W-1:0]   offset,
  input  logic [sspm_pkg::TRAVEL_W-1:0]   travel,
  output logic [sspm_pkg::SERVO_US_W-1:0] pulse_us
);
  import sspm_pkg::*;

  logic signed [17:0] ang_s;
  logic signed [17:0] ang_rnd;
  logic signed [17:0] deg_full;
  logic signed [10:0] deg;
  logic signed [10:0] off_s;
  logic signed [10:0] trav_s;
  logic signed [10:0] lo_lim;
  logic signed [10:0] hi_lim;
  logic signed [10:0] deg_off;
  logic signed [10:0] deg_trav;
  logic [7:0]         deg_fin;
  logic [28:0]        prod;

  always_comb begin
    ang_s    = reversed ? (HALF_TURN - $signed({2'b00, angle}))
                        : $signed({2'b00, angle});
    // Arithmetic shift floors, so halves round up on both signs.
    ang_rnd  = ang_s + DEG_HALF;
    deg_full = ang_rnd >>> 8;
    deg      = deg_full[10:0];
    off_s    = $signed({3'b000, offset});
    trav_s   = $signed({4'b0000, travel});
    lo_lim   = off_s - trav_s;
    hi_lim   = off_s + trav_s;
    deg_off  = deg + off_s - NEUTRAL_DEG;

    deg_trav = deg_off;
    if (deg_trav < lo_lim) begin
      deg_trav = lo_lim;
    end
    if (deg_trav > hi_lim) begin
      deg_trav = hi_lim;
    end

    if (deg_trav < 11'sd0) begin
      deg_fin = 8'd0;
    end else if (deg_trav > MAX_DEG) begin
      deg_fin = MAX_DEG[7:0];
    end else begin
      deg_fin = deg_trav[7:0];
    end

    prod     = 29'(deg_fin) * 29'(PULSE_MULT);
    pulse_us = SERVO_BASE_US + SERVO_US_W'(prod >> PULSE_SHIFT);
  end

endmodule

FILE: sim/smoothed_servo_pulse_mixer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smoothed_servo_pulse_mixer_tb
// Drives command words into the mixer and checks every pulse word against a
// cycle-free predictor of the smoothers, surface mixing and throttle scaling.
// A short directed sequence hits the field and register extremes, then about
// a thousand random words run under random register settings, with random
// gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module smoothed_servo_pulse_mixer_tb;
  import sspm_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int SINK_HOLD      = 300;
  localparam int PHASE_COUNT    = 10;
  localparam int PHASE_WORDS    = 110;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  // Angles in 1/256 degree, throttle in Q18.
  localparam int HALF_TURN_Q8   = 46080;
  localparam int ANGLE_HOME_Q8  = 23040;
  localparam int THROTTLE_FULL  = 262144;
  localparam int ANGLE_CMD_TOP  = 11520;
  localparam int ANGLE_CMD_MAX  = 16383;
  localparam int THR_CMD_TOP    = 65536;
  localparam int THR_CMD_MAX    = 131071;

  typedef struct packed {
    logic [3:0][CMD_W-1:0]  surf_cmd;
    logic [THR_CMD_W-1:0]   thr_cmd;
  } cmd_t;

  typedef struct packed {
    logic [3:0][SERVO_US_W-1:0] surf_us;
    logic [ESC_US_W-1:0]        esc_us;
  } pulse_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    cmd_t                  cmd;
    bit                    typed;
    pulse_t                want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sspm_in_if  in_ch ();
  sspm_out_if out_ch ();

  smoothed_servo_pulse_mixer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the block: register settings and smoother state.
  logic [3:0][OFFSET_W-1:0] neutral_deg;
  logic [MASK_W-1:0]        reverse_bits;
  logic [TRAVEL_W-1:0]      travel_deg;
  logic [CAP_W-1:0]         cap_pct;
  logic [3:0][ANG_W-1:0]    angle_track;
  logic [THR_W-1:0]         throttle_track;

  pulse_t pending_pulses[$];
  int     mismatch_count = 0;
  int     cycle_count    = 0;
  bit     cfg_busy       = 1'b0;
  bit     hold_sink      = 1'b0;
  bit     no_idle        = 1'b0;
  int     burst_left     = 0;
  string  surf_name[4]   = '{"left_aileron", "right_aileron", "left_tail", "right_tail"};

  // prev += floor((target - prev) / 4)
  function automatic logic [THR_W-1:0] track_step(input logic [THR_W-1:0] prev,
                                                  input logic [THR_W-1:0] target);
    int p;
    p = int'(prev);
    p = p + ((int'(target) - p) >>> 2);
    return p[THR_W-1:0];
  endfunction

  function automatic logic [SERVO_US_W-1:0] servo_us(input logic [ANG_W-1:0] angle,
                                                     input logic reversed,
                                                     input logic [OFFSET_W-1:0] neutral);
    int a, deg, off, trav;
    a = int'(angle);
    if (reversed) a = HALF_TURN_Q8 - a;
    // Arithmetic shift floors, so halves round up on both sides of zero.
    deg  = (a + 128) >>> 8;
    off  = int'(neutral);
    trav = int'(travel_deg);
    deg  = deg + off - 90;
    if (deg < off - trav) deg = off - trav;
    if (deg > off + trav) deg = off + trav;
    if (deg < 0) deg = 0;
    if (deg > 180) deg = 180;
    return SERVO_US_W'(500 + (deg * 2000) / 180);
  endfunction

  function automatic logic [ESC_US_W-1:0] esc_us(input logic [THR_W-1:0] thr);
    longint t, cap, us, top;
    t   = longint'(thr);
    cap = longint'(cap_pct);
    if (t > THROTTLE_FULL) t = THROTTLE_FULL;
    if (cap > 100) cap = 100;
    us  = 1000 + ((t * cap * 10 + THROTTLE_FULL / 2) >>> 18);
    top = 1000 + cap * 10;
    if (us > top) us = top;
    return ESC_US_W'(us);
  endfunction

  function automatic pulse_t predict_pulses(input cmd_t c);
    pulse_t p;
    logic [THR_W-1:0] t;
    for (int i = 0; i < 4; i++) begin
      t = track_step(THR_W'(angle_track[i]), THR_W'(c.surf_cmd[i]) << 2);
      angle_track[i] = t[ANG_W-1:0];
      p.surf_us[i] = servo_us(angle_track[i], reverse_bits[i], neutral_deg[i]);
    end
    throttle_track = track_step(throttle_track, THR_W'(c.thr_cmd) << 2);
    p.esc_us = esc_us(throttle_track);
    return p;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_OFFSET_LA: neutral_deg[0] = val;
      CFG_OFFSET_RA: neutral_deg[1] = val;
      CFG_OFFSET_LT: neutral_deg[2] = val;
      CFG_OFFSET_RT: neutral_deg[3] = val;
      CFG_REV_MASK:  reverse_bits   = val[MASK_W-1:0];
      CFG_TRAVEL:    travel_deg     = val[TRAVEL_W-1:0];
      CFG_THR_CAP:   cap_pct        = val[CAP_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t MISMATCH %s: got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Registers are written only with the pipeline empty.
  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    if (cfg_busy) begin
      cfg_we   <= 1'b0;
      cfg_busy = 1'b0;
    end
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_busy  = 1'b1;
    @(posedge clk);
    apply_reg(idx, val);
  endtask

  task automatic send_word(input cmd_t c, input int gap, input bit typed,
                           input pulse_t typed_us);
    pulse_t model_us;
    if (cfg_busy) begin
      cfg_we   <= 1'b0;
      cfg_busy = 1'b0;
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.left_aileron_cmd  <= c.surf_cmd[0];
    in_ch.right_aileron_cmd <= c.surf_cmd[1];
    in_ch.left_tail_cmd     <= c.surf_cmd[2];
    in_ch.right_tail_cmd    <= c.surf_cmd[3];
    in_ch.throttle_cmd      <= c.thr_cmd;
    do @(posedge clk); while (!in_ch.ready);
    model_us = predict_pulses(c);
    pending_pulses.push_back(typed ? typed_us : model_us);
  endtask

  function automatic row_t item_row(input int la, input int ra, input int lt,
                                    input int rt, input int thr);
    row_t r;
    r.kind     = ROW_ITEM;
    r.reg_idx  = '0;
    r.reg_val  = '0;
    r.cmd.surf_cmd[0] = CMD_W'(la);
    r.cmd.surf_cmd[1] = CMD_W'(ra);
    r.cmd.surf_cmd[2] = CMD_W'(lt);
    r.cmd.surf_cmd[3] = CMD_W'(rt);
    r.cmd.thr_cmd     = THR_CMD_W'(thr);
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic row_t typed_row(input int la, input int ra, input int lt,
                                     input int rt, input int thr,
                                     input int pla, input int pra, input int plt,
                                     input int prt, input int pthr);
    row_t r;
    r = item_row(la, ra, lt, rt, thr);
    r.typed = 1'b1;
    r.want.surf_us[0] = SERVO_US_W'(pla);
    r.want.surf_us[1] = SERVO_US_W'(pra);
    r.want.surf_us[2] = SERVO_US_W'(plt);
    r.want.surf_us[3] = SERVO_US_W'(prt);
    r.want.esc_us     = ESC_US_W'(pthr);
    return r;
  endfunction

  function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
    row_t r;
    r = item_row(0, 0, 0, 0, 0);
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = CFG_DATA_W'(val);
    return r;
  endfunction

  function automatic logic [CMD_W-1:0] next_angle_aim(input logic [CMD_W-1:0] cur);
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return CMD_W'($urandom_range(0, ANGLE_CMD_MAX));
    if (r <= 2) return CMD_W'($urandom_range(0, ANGLE_CMD_TOP));
    if (r == 3) begin
      case ($urandom_range(0, 2))
        0: return '0;
        1: return CMD_W'(ANGLE_CMD_TOP);
        default: return CMD_W'(ANGLE_CMD_MAX);
      endcase
    end
    return cur;
  endfunction

  function automatic logic [THR_CMD_W-1:0] next_throttle_aim(input logic [THR_CMD_W-1:0] cur);
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return THR_CMD_W'($urandom_range(0, THR_CMD_MAX));
    if (r <= 2) return THR_CMD_W'($urandom_range(0, THR_CMD_TOP));
    if (r == 3) begin
      case ($urandom_range(0, 2))
        0: return '0;
        1: return THR_CMD_W'(THR_CMD_TOP);
        default: return THR_CMD_W'(THR_CMD_MAX);
      endcase
    end
    return cur;
  endfunction

  // Mostly legal settings, with the edges and out-of-range values mixed in.
  function automatic logic [CFG_DATA_W-1:0] random_reg_value(input logic [CFG_IDX_W-1:0] idx);
    int r, v;
    r = $urandom_range(0, 7);
    case (idx)
      CFG_REV_MASK: v = $urandom_range(0, 15);
      CFG_TRAVEL: v = (r == 0) ? 0 : (r == 1) ? 90 : (r == 2) ? $urandom_range(91, 127)
                                                             : $urandom_range(0, 90);
      CFG_THR_CAP: v = (r == 0) ? 0 : (r == 1) ? 100 : (r == 2) ? $urandom_range(101, 127)
                                                               : $urandom_range(0, 100);
      default: v = (r == 0) ? 0 : (r == 1) ? 180 : (r == 2) ? $urandom_range(181, 255)
                                                           : $urandom_range(0, 180);
    endcase
    // Bits above a narrow register's width are written now and then too.
    if (idx >= CFG_REV_MASK && $urandom_range(0, 5) == 0) v = v | 128;
    return CFG_DATA_W'(v);
  endfunction

  // Receiver: random readiness, plus one long hold-off on request.
  initial begin
    int mode, mode_left;
    out_ch.ready = 1'b0;
    mode = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        hold_sink = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 300);
        end
        mode_left--;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 1) == 1);
          2: out_ch.ready <= ($urandom_range(0, 9) != 0);
          default: out_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_pulses
    pulse_t seen, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.surf_us[0] = out_ch.left_aileron_pulse_us;
      seen.surf_us[1] = out_ch.right_aileron_pulse_us;
      seen.surf_us[2] = out_ch.left_tail_pulse_us;
      seen.surf_us[3] = out_ch.right_tail_pulse_us;
      seen.esc_us     = out_ch.throttle_pulse_us;
      if (pending_pulses.size() == 0) begin
        report_mismatch("word with nothing pending, throttle pulse", int'(seen.esc_us), 0);
      end else begin
        want = pending_pulses.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (seen.surf_us[i] !== want.surf_us[i])
            report_mismatch({surf_name[i], " pulse"}, int'(seen.surf_us[i]),
                            int'(want.surf_us[i]));
        end
        if (seen.esc_us !== want.esc_us)
          report_mismatch("throttle pulse", int'(seen.esc_us), int'(want.esc_us));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    row_t   directed_rows[$];
    cmd_t   c, aim;
    pulse_t none;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    in_ch.valid = 1'b0;
    in_ch.left_aileron_cmd  = '0;
    in_ch.right_aileron_cmd = '0;
    in_ch.left_tail_cmd     = '0;
    in_ch.right_tail_cmd    = '0;
    in_ch.throttle_cmd      = '0;
    neutral_deg[0] = 8'd90;
    neutral_deg[1] = 8'd87;
    neutral_deg[2] = 8'd100;
    neutral_deg[3] = 8'd90;
    reverse_bits   = 4'd5;
    travel_deg     = 7'd30;
    cap_pct        = 7'd60;
    for (int i = 0; i < 4; i++) angle_track[i] = ANG_W'(ANGLE_HOME_Q8);
    throttle_track = '0;
    none = '0;

    // Defaults after reset: a 90 degree command leaves every smoother at rest.
    directed_rows.push_back(typed_row(5760, 5760, 5760, 5760, 0,
                                      1500, 1466, 1611, 1500, 1000));
    directed_rows.push_back(item_row(0, 0, 0, 0, THR_CMD_TOP));
    directed_rows.push_back(item_row(0, 0, 0, 0, THR_CMD_TOP));
    directed_rows.push_back(item_row(11520, 11520, 11520, 11520, THR_CMD_TOP));
    directed_rows.push_back(item_row(11520, 11520, 11520, 11520, 0));
    directed_rows.push_back(item_row(16383, 16383, 16383, 16383, THR_CMD_MAX));
    directed_rows.push_back(item_row(16383, 16383, 16383, 16383, THR_CMD_MAX));
    directed_rows.push_back(item_row(16383, 16383, 16383, 16383, THR_CMD_MAX));
    directed_rows.push_back(item_row(0, 16383, 0, 16383, 1));
    // Everything reversed, offsets and limits at or beyond the ends of their legal ranges.
    directed_rows.push_back(reg_row(CFG_REV_MASK, 15));
    directed_rows.push_back(reg_row(CFG_TRAVEL, 127));
    directed_rows.push_back(reg_row(CFG_THR_CAP, 127));
    directed_rows.push_back(reg_row(CFG_OFFSET_LA, 255));
    directed_rows.push_back(reg_row(CFG_OFFSET_RA, 181));
    directed_rows.push_back(reg_row(CFG_OFFSET_LT, 0));
    directed_rows.push_back(reg_row(CFG_OFFSET_RT, 180));
    directed_rows.push_back(item_row(16383, 16383, 16383, 16383, THR_CMD_MAX));
    directed_rows.push_back(item_row(0, 0, 0, 0, 0));
    directed_rows.push_back(item_row(11520, 0, 11520, 0, THR_CMD_TOP));
    directed_rows.push_back(item_row(5760, 5760, 5760, 5760, 70000));
    // Zero travel pins each surface to its clamped offset; zero cap pins idle.
    directed_rows.push_back(reg_row(CFG_TRAVEL, 0));
    directed_rows.push_back(reg_row(CFG_OFFSET_LA, 0));
    directed_rows.push_back(reg_row(CFG_OFFSET_RA, 180));
    directed_rows.push_back(reg_row(CFG_OFFSET_LT, 255));
    directed_rows.push_back(reg_row(CFG_OFFSET_RT, 45));
    directed_rows.push_back(reg_row(CFG_THR_CAP, 0));
    directed_rows.push_back(reg_row(CFG_REV_MASK, 10));
    directed_rows.push_back(typed_row(0, 0, 0, 0, 0, 500, 2500, 2500, 1000, 1000));
    directed_rows.push_back(typed_row(16383, 16383, 16383, 16383, THR_CMD_MAX,
                                      500, 2500, 2500, 1000, 1000));
    // Unused index, and upper data bits on the narrow registers.
    directed_rows.push_back(reg_row(CFG_SPARE_IDX, 255));
    directed_rows.push_back(reg_row(CFG_OFFSET_LA, 90));
    directed_rows.push_back(reg_row(CFG_OFFSET_RA, 87));
    directed_rows.push_back(reg_row(CFG_OFFSET_LT, 100));
    directed_rows.push_back(reg_row(CFG_OFFSET_RT, 90));
    directed_rows.push_back(reg_row(CFG_REV_MASK, 8'hF5));
    directed_rows.push_back(reg_row(CFG_TRAVEL, 8'h9E));
    directed_rows.push_back(reg_row(CFG_THR_CAP, 8'hE4));
    directed_rows.push_back(item_row(8192, 3000, 11000, 100, 32768));
    directed_rows.push_back(item_row(1, 2, 3, 4, 5));
    directed_rows.push_back(item_row(11519, 11521, 64, 63, 65535));
    directed_rows.push_back(item_row(10000, 2000, 16000, 500, 131000));
    directed_rows.push_back(item_row(5760, 5760, 5760, 5760, 32768));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_REG) begin
        if (!cfg_busy) drain_pipeline();
        write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
      end else begin
        send_word(directed_rows[k].cmd, pick_gap(), directed_rows[k].typed,
                  directed_rows[k].want);
      end
    end

    aim = directed_rows[directed_rows.size() - 1].cmd;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      drain_pipeline();
      no_idle = (phase % 3 == 1);
      if (phase == 0) begin
        for (int i = 0; i < 4; i++) write_reg(CFG_IDX_W'(CFG_OFFSET_LA + i), 180);
        write_reg(CFG_REV_MASK, 15);
        write_reg(CFG_TRAVEL, 90);
        write_reg(CFG_THR_CAP, 100);
      end else if (phase == PHASE_COUNT - 1) begin
        for (int i = 0; i < 4; i++) write_reg(CFG_IDX_W'(CFG_OFFSET_LA + i), 0);
        write_reg(CFG_REV_MASK, 0);
        write_reg(CFG_TRAVEL, 127);
        write_reg(CFG_THR_CAP, 127);
      end else begin
        for (int idx = 0; idx <= CFG_THR_CAP; idx++) begin
          if ($urandom_range(0, 1) == 1)
            write_reg(CFG_IDX_W'(idx), random_reg_value(CFG_IDX_W'(idx)));
        end
        if ($urandom_range(0, 3) == 0)
          write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom_range(0, 255)));
      end

      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Back up the pipeline behind a stalled receiver.
        if (phase == 2 && n == 20) begin
          hold_sink  = 1'b1;
          burst_left = 40;
        end
        if (phase == 5 && n == 55) drain_pipeline();
        if ($urandom_range(0, 31) == 0) begin
          for (int i = 0; i < 4; i++) c.surf_cmd[i] = CMD_W'($urandom_range(0, ANGLE_CMD_MAX));
          c.thr_cmd = THR_CMD_W'($urandom_range(0, THR_CMD_MAX));
        end else begin
          // Held targets let the smoothers settle into the clamps.
          for (int i = 0; i < 4; i++) aim.surf_cmd[i] = next_angle_aim(aim.surf_cmd[i]);
          aim.thr_cmd = next_throttle_aim(aim.thr_cmd);
          c = aim;
        end
        send_word(c, pick_gap(), 1'b0, none);
      end
    end

    drain_pipeline();
    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/sspm_pkg.sv
rtl/sspm_in_if.sv
rtl/sspm_out_if.sv
rtl/sspm_surface.sv
rtl/smoothed_servo_pulse_mixer.sv
sim/smoothed_servo_pulse_mixer_tb.sv
